/* rtl/core/crtc_beam_timing_with_port_core_assert.svh */
// Assertion macros shared by the CRTC core.
`ifndef CRTC_BEAM_TIMING_WITH_PORT_CORE_ASSERT_SVH
`define CRTC_BEAM_TIMING_WITH_PORT_CORE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define CRTC_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the same cycle.
`define CRTC_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define CRTC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/crtc_pkg.sv */
// Types, codes and helper functions of the CRTC core.
package crtc_pkg;

    localparam int NUM_TIMING_REGS = 18;
    localparam int IDX_W           = 5;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2
    } crtc_req_t;

    // Port offsets above the index/data pairs.
    localparam logic [3:0] PORT_MODE   = 4'd8;
    localparam logic [3:0] PORT_COLOR  = 4'd9;
    localparam logic [3:0] PORT_STATUS = 4'd10;
    localparam logic [3:0] PORT_SPARE0 = 4'd11;
    localparam logic [3:0] PORT_SPARE1 = 4'd12;

    // Timing register numbers.
    localparam logic [IDX_W-1:0] REG_H_TOTAL   = 5'd0;
    localparam logic [IDX_W-1:0] REG_H_DISP    = 5'd1;
    localparam logic [IDX_W-1:0] REG_V_TOTAL   = 5'd4;
    localparam logic [IDX_W-1:0] REG_V_ADJ     = 5'd5;
    localparam logic [IDX_W-1:0] REG_V_DISP    = 5'd6;
    localparam logic [IDX_W-1:0] REG_V_SYNC    = 5'd7;
    localparam logic [IDX_W-1:0] REG_MAX_SCAN  = 5'd9;
    localparam logic [IDX_W-1:0] REG_CUR_START = 5'd10;
    localparam logic [IDX_W-1:0] REG_CUR_END   = 5'd11;
    localparam logic [IDX_W-1:0] REG_START_HI  = 5'd12;
    localparam logic [IDX_W-1:0] REG_START_LO  = 5'd13;

    localparam logic [7:0] ZERO_WIDTH_STRIDE = 8'd80;
    localparam logic [3:0] DOTS_PER_TICK     = 4'd3;
    localparam logic [3:0] ACCESS_OFFSET     = 4'd5;

    typedef logic [NUM_TIMING_REGS-1:0][7:0] crtc_regfile_t;

    typedef struct packed {
        logic [7:0]  h_total;
        logic [7:0]  h_disp;
        logic [6:0]  v_total;
        logic [4:0]  v_adj;
        logic [6:0]  v_disp;
        logic [6:0]  v_sync;
        logic [4:0]  max_scan;
        logic [13:0] frame_start;
        logic        hires;
    } crtc_cfg_t;

    typedef struct packed {
        logic disp_off;
        logic vsync;
    } crtc_status_t;

    typedef struct packed {
        logic [13:0] mem_address;
        logic [4:0]  row_scan;
        logic [6:0]  row_count;
        logic [7:0]  char_count;
        logic        vsync;
        logic        line_done;
        logic [3:0]  wait_clocks;
    } crtc_beam_t;

    // Bus wait clocks: ceil((d + 9) / 3) for a distance d of 0 to 15 dots.
    function automatic logic [3:0] wait_lookup(input logic [3:0] d);
        logic [3:0] w;
        if (d == 4'd0)
            w = 4'd3;
        else if (d <= 4'd3)
            w = 4'd4;
        else if (d <= 4'd6)
            w = 4'd5;
        else if (d <= 4'd9)
            w = 4'd6;
        else if (d <= 4'd12)
            w = 4'd7;
        else
            w = 4'd8;
        return w;
    endfunction

endpackage

/* rtl/core/crtc_if.sv */
// Request and response channel interfaces of the CRTC core.
interface crtc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [3:0] port_offset;
    logic [7:0] write_data;

    modport source (output valid, output req_type, output port_offset, output write_data,
                    input ready);
    modport sink (input valid, input req_type, input port_offset, input write_data,
                  output ready);
endinterface

interface crtc_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [13:0] mem_address;
    logic [4:0]  row_scan;
    logic [6:0]  row_count;
    logic [7:0]  char_count;
    logic        display_on;
    logic        vsync_active;
    logic        line_done;
    logic [3:0]  wait_clocks;

    modport source (output valid, output read_data, output mem_address, output row_scan,
                    output row_count, output char_count, output display_on,
                    output vsync_active, output line_done, output wait_clocks,
                    input ready);
    modport sink (input valid, input read_data, input mem_address, input row_scan,
                  input row_count, input char_count, input display_on,
                  input vsync_active, input line_done, input wait_clocks,
                  output ready);
endinterface

/* rtl/core/crtc_regs.sv */
// Port window: index register, timing register file, mode flag and read mux.
module crtc_regs
    import crtc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         go,
    input  logic [1:0]   req_type,
    input  logic [3:0]   port_offset,
    input  logic [7:0]   write_data,
    input  crtc_status_t status,
    output crtc_cfg_t    cfg,
    output crtc_cfg_t    cfg_next,
    output logic [7:0]   read_data
);

    crtc_regfile_t    regs_reg;
    crtc_regfile_t    regs_next;
    logic [IDX_W-1:0] index_reg;
    logic [IDX_W-1:0] index_next;
    logic             hires_reg;
    logic             hires_next;
    logic             index_valid;
    logic [7:0]       masked_data;

    function automatic crtc_cfg_t cfg_of(input crtc_regfile_t r, input logic hires);
        crtc_cfg_t c;
        c.h_total     = r[REG_H_TOTAL];
        c.h_disp      = r[REG_H_DISP];
        c.v_total     = r[REG_V_TOTAL][6:0];
        c.v_adj       = r[REG_V_ADJ][4:0];
        c.v_disp      = r[REG_V_DISP][6:0];
        c.v_sync      = r[REG_V_SYNC][6:0];
        c.max_scan    = r[REG_MAX_SCAN][4:0];
        c.frame_start = {r[REG_START_HI][5:0], r[REG_START_LO]};
        c.hires       = hires;
        return c;
    endfunction

    assign index_valid = (index_reg < IDX_W'(NUM_TIMING_REGS));

    always_comb
    begin
        case (index_reg) inside
            REG_V_TOTAL, REG_V_DISP:     masked_data = write_data & 8'h7F;
            REG_MAX_SCAN, REG_CUR_END:   masked_data = write_data & 8'h1F;
            REG_CUR_START, REG_START_HI: masked_data = write_data & 8'h3F;
            default:                     masked_data = write_data;
        endcase
    end

    // The offsets below eight alternate between index (even) and data (odd).
    always_comb
    begin
        regs_next  = regs_reg;
        index_next = index_reg;
        hires_next = hires_reg;
        if (go && req_type == REQ_WRITE)
        begin
            if (!port_offset[3])
            begin
                if (!port_offset[0])
                    index_next = write_data[IDX_W-1:0];
                else if (index_valid)
                    regs_next[index_reg] = masked_data;
            end
            else if (port_offset == PORT_MODE)
            begin
                hires_next = write_data[0] | write_data[4];
            end
        end
    end

    always_comb
    begin
        read_data = 8'h00;
        if (req_type == REQ_READ)
        begin
            if (!port_offset[3])
            begin
                if (!port_offset[0])
                    read_data = {{(8-IDX_W){1'b0}}, index_reg};
                else if (index_valid)
                    read_data = regs_reg[index_reg];
            end
            else
            begin
                case (port_offset) inside
                    PORT_STATUS:
                        read_data = {4'b0000, status.vsync, 2'b00, status.disp_off};
                    PORT_MODE, PORT_COLOR, PORT_SPARE0, PORT_SPARE1:
                        read_data = 8'h00;
                    default:
                        read_data = 8'hFF;
                endcase
            end
        end
    end

    assign cfg      = cfg_of(regs_reg, hires_reg);
    assign cfg_next = cfg_of(regs_next, hires_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg  <= '0;
            index_reg <= '0;
            hires_reg <= 1'b0;
        end
        else
        begin
            regs_reg  <= regs_next;
            index_reg <= index_next;
            hires_reg <= hires_next;
        end
    end

endmodule

/* rtl/core/crtc_timing.sv */
// Beam counters: dot, character, scanline, row, adjust, vsync and access phase.
module crtc_timing
    import crtc_pkg::*;
#(
    parameter int VSYNC_LENGTH = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         tick,
    input  crtc_cfg_t    cfg,
    output crtc_beam_t   beam,
    output crtc_status_t status
);

    localparam int LINES_W = $clog2(VSYNC_LENGTH + 1);

    logic [4:0]         dot_reg,      dot_next;
    logic [7:0]         char_reg,     char_next;
    logic [4:0]         scan_reg,     scan_next;
    logic [6:0]         row_reg,      row_next;
    logic [13:0]        addr_reg,     addr_next;
    logic [4:0]         adjust_reg,   adjust_next;
    logic               in_adjust_reg, in_adjust_next;
    logic               vsync_reg,    vsync_next;
    logic [LINES_W-1:0] lines_reg,    lines_next;
    logic [3:0]         phase_reg,    phase_next;

    logic [4:0] per_char;
    logic [4:0] dot_sum;
    logic       char_step;
    logic [8:0] char_inc;
    logic       line_end;
    logic [7:0] stride;
    logic [5:0] adjust_inc;

    assign per_char   = cfg.hires ? 5'd8 : 5'd16;
    assign dot_sum    = dot_reg + 5'(DOTS_PER_TICK);
    assign char_step  = tick && (dot_sum >= per_char);
    assign char_inc   = {1'b0, char_reg} + 9'd1;
    assign line_end   = char_step && (char_inc > {1'b0, cfg.h_total});
    assign stride     = (cfg.h_disp == 8'd0) ? ZERO_WIDTH_STRIDE : cfg.h_disp;
    assign adjust_inc = {1'b0, adjust_reg} + 6'd1;

    always_comb
    begin
        dot_next       = dot_reg;
        char_next      = char_reg;
        scan_next      = scan_reg;
        row_next       = row_reg;
        addr_next      = addr_reg;
        adjust_next    = adjust_reg;
        in_adjust_next = in_adjust_reg;
        vsync_next     = vsync_reg;
        lines_next     = lines_reg;
        phase_next     = phase_reg;

        if (tick)
        begin
            phase_next = phase_reg + DOTS_PER_TICK;
            dot_next   = char_step ? (dot_sum - per_char) : dot_sum;
        end

        if (char_step)
            char_next = line_end ? 8'd0 : char_inc[7:0];

        if (line_end)
        begin
            if (in_adjust_reg)
            begin
                adjust_next = adjust_inc[4:0];
                if (adjust_inc >= {1'b0, cfg.v_adj})
                begin
                    in_adjust_next = 1'b0;
                    adjust_next    = 5'd0;
                    row_next       = 7'd0;
                    scan_next      = 5'd0;
                    addr_next      = cfg.frame_start;
                end
            end
            else if (scan_reg >= cfg.max_scan)
            begin
                scan_next = 5'd0;
                if (row_reg == cfg.v_total)
                begin
                    if (cfg.v_adj == 5'd0)
                    begin
                        row_next  = 7'd0;
                        addr_next = cfg.frame_start;
                    end
                    else
                    begin
                        in_adjust_next = 1'b1;
                        adjust_next    = 5'd0;
                    end
                end
                else
                begin
                    row_next  = row_reg + 7'd1;
                    addr_next = addr_reg + {6'd0, stride};
                end
            end
            else
            begin
                scan_next = scan_reg + 5'd1;
            end

            // Sync starts on the first scanline of the sync row and counts lines.
            if (!vsync_reg && row_next == cfg.v_sync && scan_next == 5'd0)
            begin
                vsync_next = 1'b1;
                lines_next = '0;
            end
            if (vsync_next)
            begin
                lines_next = lines_next + 1'b1;
                if (lines_next >= LINES_W'(VSYNC_LENGTH))
                    vsync_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg       <= '0;
            char_reg      <= '0;
            scan_reg      <= '0;
            row_reg       <= '0;
            addr_reg      <= '0;
            adjust_reg    <= '0;
            in_adjust_reg <= 1'b0;
            vsync_reg     <= 1'b0;
            lines_reg     <= '0;
            phase_reg     <= '0;
        end
        else
        begin
            dot_reg       <= dot_next;
            char_reg      <= char_next;
            scan_reg      <= scan_next;
            row_reg       <= row_next;
            addr_reg      <= addr_next;
            adjust_reg    <= adjust_next;
            in_adjust_reg <= in_adjust_next;
            vsync_reg     <= vsync_next;
            lines_reg     <= lines_next;
            phase_reg     <= phase_next;
        end
    end

    assign beam.mem_address = addr_next;
    assign beam.row_scan    = scan_next;
    assign beam.row_count   = row_next;
    assign beam.char_count  = char_next;
    assign beam.vsync       = vsync_next;
    assign beam.line_done   = line_end;
    assign beam.wait_clocks = wait_lookup(ACCESS_OFFSET - phase_next);

    assign status.disp_off = (char_reg >= cfg.h_disp) || ({1'b0, row_reg} >= {1'b0, cfg.v_disp});
    assign status.vsync    = vsync_reg;

endmodule

/* rtl/core/crtc_beam_timing_with_port_core.sv */
// A word taken into the input register moves on into the result register once that is empty or being taken.
// Throughput: one word per cycle while rsp.ready holds, ticks, port reads and port writes alike.
// The input register frees itself whenever the result register is empty or being taken.
// Reset (rst_n, asynchronous, active low) clears all timing registers, counters and valids.
// No clearing pass follows reset; the first word can be taken as soon as reset is released.
`include "crtc_beam_timing_with_port_core_assert.svh"

module crtc_beam_timing_with_port_core
    import crtc_pkg::*;
#(
    parameter int VSYNC_LENGTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    crtc_req_if.sink   req,
    crtc_rsp_if.source rsp
);

    logic       s1_valid_reg;
    logic [1:0] s1_req_reg;
    logic [3:0] s1_port_reg;
    logic [7:0] s1_data_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_read_reg;
    crtc_beam_t  out_beam_reg;
    logic        out_disp_reg;

    logic         go;
    logic         tick;
    logic         take;
    crtc_cfg_t    cfg;
    crtc_cfg_t    cfg_next;
    crtc_status_t status;
    crtc_beam_t   beam;
    logic [7:0]   read_data;
    logic         disp_next;

    assign go   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign tick = go && (s1_req_reg == REQ_TICK);
    assign take = req.valid && req.ready;

    assign req.ready = !s1_valid_reg || go;

    crtc_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .req_type    (s1_req_reg),
        .port_offset (s1_port_reg),
        .write_data  (s1_data_reg),
        .status      (status),
        .cfg         (cfg),
        .cfg_next    (cfg_next),
        .read_data   (read_data)
    );

    crtc_timing #(
        .VSYNC_LENGTH (VSYNC_LENGTH)
    ) u_timing (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick),
        .cfg    (cfg),
        .beam   (beam),
        .status (status)
    );

    // Display enable is judged on the state left behind by this word.
    assign disp_next = (beam.char_count < cfg_next.h_disp) &&
                       ({1'b0, beam.row_count} < {1'b0, cfg_next.v_disp});

    always_comb
    begin
        if (go)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                s1_valid_reg <= req.valid;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_req_reg  <= req.req_type;
            s1_port_reg <= req.port_offset;
            s1_data_reg <= req.write_data;
        end
        if (go)
        begin
            out_read_reg <= read_data;
            out_beam_reg <= beam;
            out_disp_reg <= disp_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_data    = out_read_reg;
    assign rsp.mem_address  = out_beam_reg.mem_address;
    assign rsp.row_scan     = out_beam_reg.row_scan;
    assign rsp.row_count    = out_beam_reg.row_count;
    assign rsp.char_count   = out_beam_reg.char_count;
    assign rsp.display_on   = out_disp_reg;
    assign rsp.vsync_active = out_beam_reg.vsync;
    assign rsp.line_done    = out_beam_reg.line_done;
    assign rsp.wait_clocks  = out_beam_reg.wait_clocks;

    `CRTC_ASSERT_IMPLY(a_line_done_char_zero, go && beam.line_done, beam.char_count == 8'd0, "scanline ended without clearing the character counter")
    `CRTC_ASSERT_IMPLY(a_vsync_rise_on_line, go && beam.vsync && !status.vsync, beam.line_done, "vertical sync started away from a scanline end")
    `CRTC_ASSERT_IMPLY(a_wait_range, out_valid_reg, out_beam_reg.wait_clocks >= 4'd3 && out_beam_reg.wait_clocks <= 4'd8, "wait count out of range")
    `CRTC_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !go, s1_valid_reg, "stalled input word was dropped")

endmodule
